[rtl/eltbl_pkg.sv]
`timescale 1ns / 1ps
package eltbl_pkg;

  localparam int unsigned NumCutoffs = 5;
  localparam logic [21:0] DegPerRadQ16 = 22'd3754936;
  localparam logic [15:0] MinMomentum = 16'd160;
  localparam logic [16:0] CutoffMargin = 17'd160;
  localparam logic [21:0] DegLo = 22'd196608;   // 12 degrees, Q.14
  localparam logic [21:0] DegHi = 22'd2752512;  // 168 degrees
  localparam logic [21:0] Deg90 = 22'd1474560;
  localparam logic [21:0] Deg180 = 22'd2949120;
  localparam logic [6:0] MomBinWidth = 7'd80;
  localparam logic [20:0] Scale = 21'd1310720;  // 80 * 2^14
  localparam logic [20:0] HalfScale = 21'd655360;

  localparam logic [15:0] CodeProton = 16'd2212;
  localparam logic [15:0] CodeDeuteron = 16'd45;
  localparam logic [15:0] CodeTriton = 16'd46;
  localparam logic [15:0] CodeHelium3 = 16'd49;
  localparam logic [15:0] CodeHelium4 = 16'd47;

  typedef enum logic [2:0] {
    ST_INTERP = 3'd0,
    ST_CUTOFF = 3'd1,
    ST_RANGE = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_HOLE_NONE = 3'd4,
    ST_HOLE_SUB = 3'd5
  } status_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // species 0..4 from particle code; valid=0 on unknown
  typedef struct packed {
    logic valid;
    logic [2:0] idx;
  } species_t;

  function automatic species_t species_of(input logic [15:0] code);
    species_t s;
    s.valid = 1'b1;
    s.idx = 3'd0;
    case (code)
      CodeProton: s.idx = 3'd0;
      CodeDeuteron: s.idx = 3'd1;
      CodeTriton: s.idx = 3'd2;
      CodeHelium3: s.idx = 3'd3;
      CodeHelium4: s.idx = 3'd4;
      default: s.valid = 1'b0;
    endcase
    return s;
  endfunction

endpackage

[rtl/eltbl_mem.sv]
`timescale 1ns / 1ps
// Table storage with a per-entry clearing sweep after reset.
module eltbl_mem #(
  parameter int unsigned DEPTH = 271500,
  parameter int unsigned AW = 19
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata,
  output logic          busy
);

  logic [15:0] mem [DEPTH];
  logic [AW-1:0] clr_r, clr_nxt;
  logic busy_r, busy_nxt;

  always_comb begin
    clr_nxt = clr_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      if (clr_r == AW'(DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        clr_nxt = clr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      busy_r <= 1'b1;
    end else begin
      clr_r <= clr_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_r] <= 16'd0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign busy = busy_r;

endmodule

[rtl/eltbl_mac.sv]
`timescale 1ns / 1ps
// Shared signed multiply-accumulate: acc <= (clr ? 0 : acc) + a * b.
module eltbl_mac (
  input  logic               clk,
  input  logic               en,
  input  logic               clr,
  input  logic signed [22:0] a,
  input  logic signed [17:0] b,
  output logic signed [41:0] acc
);

  logic signed [41:0] acc_r;
  logic signed [41:0] prod;

  assign prod = 42'(a) * 42'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= (clr ? 42'sd0 : acc_r) + prod;
    end
  end

  assign acc = acc_r;

endmodule

[rtl/energy_loss_table_interpolator.sv]
`timescale 1ns / 1ps
// Energy-loss table interpolator. After reset the table memory is cleared one word per
// cycle, all SPECIES*ANGLE_BINS*MOMENTUM_BINS words (271500 at defaults), with in_tready
// low. A write goes through S_WRITE. A query with an unknown particle code goes straight
// to the output; one rejected by the range check or passed through above the cutoff
// stops after the angle multiply and checks; an interpolated query runs the angle
// multiply, checks, divide-by-80 multiply, bins, four table reads (S_RD, S_RDWAIT each),
// three multiply-accumulate steps, rounding and a final divide by 80. The angle, divide
// and plane multiplies share one multiply-accumulate unit, and all reads share one table
// read port. A hole among the four corners starts a search of up to HOLE_SEARCH_LIMIT
// steps of at most five table reads each. One request is in flight at a time; the result
// waits in the output register while the next request may be taken, and a finished query
// holds until that register is free.
module energy_loss_table_interpolator #(
  parameter int unsigned SPECIES = 5,
  parameter int unsigned ANGLE_BINS = 181,
  parameter int unsigned MOMENTUM_BINS = 300,
  parameter int unsigned HOLE_SEARCH_LIMIT = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[0], write_species[3:1], write_angle_bin[11:4], write_momentum_bin[20:12],
  // write_value[36:21], particle_code[52:37], theta[68:53], drift_momentum[84:69]
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // vertex_momentum[15:0]
  output logic [15:0] out_tdata,
  // status[2:0]
  output logic [2:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned DEPTH = SPECIES * ANGLE_BINS * MOMENTUM_BINS;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned ROW = MOMENTUM_BINS;
  localparam int unsigned PLANE = ANGLE_BINS * MOMENTUM_BINS;

  // input fields
  logic        f_op;
  logic [2:0]  f_wsp;
  logic [7:0]  f_wang;
  logic [8:0]  f_wmom;
  logic [15:0] f_wval, f_code, f_theta, f_p;
  assign f_op = in_tdata[0];
  assign f_wsp = in_tdata[3:1];
  assign f_wang = in_tdata[11:4];
  assign f_wmom = in_tdata[20:12];
  assign f_wval = in_tdata[36:21];
  assign f_code = in_tdata[52:37];
  assign f_theta = in_tdata[68:53];
  assign f_p = in_tdata[84:69];

  // config
  logic [15:0] cut_r [eltbl_pkg::NumCutoffs];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_r[0] <= 16'd12880;
      cut_r[1] <= 16'd15120;
      cut_r[2] <= 16'd17280;
      cut_r[3] <= 16'd20080;
      cut_r[4] <= 16'd22560;
    end else if (cfg_we && cfg_index < 3'(eltbl_pkg::NumCutoffs)) begin
      cut_r[cfg_index] <= cfg_wdata;
    end
  end

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_DEG, S_CHECK, S_DIV, S_BINS, S_RD, S_RDWAIT, S_PLANE1,
    S_PLANE2, S_PLANE3, S_ROUND, S_HOLE, S_HWAIT, S_OUT
  } state_t;

  state_t state_r;
  logic [2:0]  sp_r;
  logic [15:0] theta_r, p_r;
  logic [21:0] t_r;
  logic [7:0]  kk_r;
  logic [13:0] fy_r;
  logic [9:0]  mm_r;
  logic [6:0]  fx_r;
  logic [15:0] c_r [4];
  logic [2:0]  ri_r;
  logic [7:0]  hm_r;
  logic [15:0] res_r;
  logic [2:0]  st_r;
  logic        ovld_r;
  logic [15:0] w0_r;

  // memory
  logic          mwe;
  logic [AW-1:0] mwaddr, mraddr;
  logic [15:0]   mrdata;
  logic          mbusy;
  logic          rd_ok_r;

  eltbl_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk(clk), .rst_n(rst_n), .we(mwe), .waddr(mwaddr), .wdata(w0_r),
    .raddr(mraddr), .rdata(mrdata), .busy(mbusy)
  );

  // address registers for write
  logic [AW-1:0] waddr_r;
  logic          wok_r;
  assign mwe = (state_r == S_WRITE) && wok_r;
  assign mwaddr = waddr_r;

  // read address: offsets per read index
  logic [9:0] r_ang, r_mom;
  always_comb begin
    r_ang = {2'b0, kk_r};
    r_mom = mm_r;
    case (ri_r)
      3'd1: r_mom = mm_r + 10'd1;
      3'd2: r_ang = {2'b0, kk_r} + 10'd1;
      3'd3: begin r_ang = {2'b0, kk_r} + 10'd1; r_mom = mm_r + 10'd1; end
      3'd4: r_mom = mm_r + 10'd2;
      default: ;
    endcase
  end
  logic rd_ok;
  assign rd_ok = (r_ang < 10'(ANGLE_BINS)) && (r_mom < 10'(MOMENTUM_BINS));
  // species plane base is a small constant multiply; angle row one 10x10 product
  assign mraddr = AW'(32'(sp_r) * PLANE + 32'(r_ang) * ROW + 32'(r_mom));
  logic [15:0] rword;
  assign rword = rd_ok_r ? mrdata : 16'd0;

  // shared MAC
  logic mac_en, mac_clr;
  logic signed [22:0] mac_a;
  logic signed [17:0] mac_b;
  logic signed [41:0] acc;
  eltbl_mac u_mac (.clk(clk), .en(mac_en), .clr(mac_clr), .a(mac_a), .b(mac_b), .acc(acc));

  // plane coefficients
  logic signed [17:0] ca, cbx, cby;
  logic lo_p, lo_t;
  always_comb begin
    lo_p = fx_r < 7'd40;
    lo_t = fy_r < 14'd8192;
    ca = 18'(c_r[0]);
    cbx = 18'(c_r[1]) - 18'(c_r[0]);
    cby = 18'(c_r[2]) - 18'(c_r[0]);
    if (lo_p && lo_t) begin
      ca = 18'(c_r[0]);
    end else if (lo_t) begin
      cby = 18'(c_r[3]) - 18'(c_r[1]);
    end else if (lo_p) begin
      cbx = 18'(c_r[3]) - 18'(c_r[2]);
    end else begin
      ca = 18'(c_r[1]) + 18'(c_r[2]) - 18'(c_r[3]);
      cbx = 18'(c_r[3]) - 18'(c_r[2]);
      cby = 18'(c_r[3]) - 18'(c_r[1]);
    end
  end

  always_comb begin
    mac_en = 1'b1;
    mac_clr = 1'b1;
    mac_a = '0;
    mac_b = '0;
    case (state_r)
      S_DEG: begin
        mac_a = 23'(eltbl_pkg::DegPerRadQ16);
        mac_b = 18'(theta_r);
      end
      S_DIV: begin
        // p/80 = (p * 52429) >> 22 for p < 2^16
        mac_a = 23'sd52429;
        mac_b = 18'(p_r);
      end
      S_PLANE1: begin
        mac_a = 23'(eltbl_pkg::Scale);
        mac_b = ca;
      end
      S_PLANE2: begin
        mac_clr = 1'b0;
        mac_a = 23'({fx_r, 14'd0});
        mac_b = cbx;
      end
      S_PLANE3: begin
        mac_clr = 1'b0;
        mac_a = 23'(fy_r) * 23'd80;
        mac_b = cby;
      end
      default: mac_en = 1'b0;
    endcase
  end

  eltbl_pkg::species_t spc;
  assign spc = eltbl_pkg::species_of(f_code);
  logic [41:0] rnd;
  assign rnd = acc + 42'(eltbl_pkg::HalfScale);
  // rnd / (80*2^14) = (rnd >> 14) / 80; acc < 2^38 so (rnd>>14) < 2^24
  logic [23:0] rsh;
  assign rsh = rnd[37:14];

  logic [23:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && (!ovld_r || out_tready)) begin
        ovld_r <= 1'b1;
      end else if (out_tvalid && out_tready) begin
        ovld_r <= 1'b0;
      end
      rd_ok_r <= rd_ok;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            if (f_op == eltbl_pkg::OP_WRITE) begin
              waddr_r <= AW'(32'(f_wsp) * PLANE + 32'(f_wang) * ROW + 32'(f_wmom));
              wok_r <= (4'(f_wsp) < 4'(SPECIES)) && (9'(f_wang) < 9'(ANGLE_BINS))
                       && (10'(f_wmom) < 10'(MOMENTUM_BINS));
              w0_r <= f_wval;
              state_r <= S_WRITE;
            end else begin
              theta_r <= f_theta;
              p_r <= f_p;
              sp_r <= spc.idx;
              res_r <= 16'd0;
              if (!spc.valid || 4'(spc.idx) >= 4'(SPECIES)) begin
                st_r <= eltbl_pkg::ST_UNKNOWN;
                state_r <= S_OUT;
              end else begin
                state_r <= S_DEG;
              end
            end
          end
        end
        S_WRITE: state_r <= S_IDLE;
        S_DEG: state_r <= S_CHECK;
        S_CHECK: begin
          t_r <= acc[37:16];
          if (acc[41:16] <= 26'(eltbl_pkg::DegLo) || acc[41:16] >= 26'(eltbl_pkg::DegHi)
              || p_r < eltbl_pkg::MinMomentum) begin
            st_r <= eltbl_pkg::ST_RANGE;
            state_r <= S_OUT;
          end else if (17'(p_r) + eltbl_pkg::CutoffMargin >= 17'(cut_r[sp_r])) begin
            res_r <= p_r;
            st_r <= eltbl_pkg::ST_CUTOFF;
            state_r <= S_OUT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (t_r < eltbl_pkg::Deg90) t_r <= eltbl_pkg::Deg180 - t_r;
          state_r <= S_BINS;
        end
        S_BINS: begin
          kk_r <= t_r[21:14];
          fy_r <= t_r[13:0];
          mm_r <= 10'(acc[41:22]);
          fx_r <= 7'(p_r - 16'(acc[41:22]) * 16'(eltbl_pkg::MomBinWidth));
          ri_r <= 3'd0;
          state_r <= S_RD;
        end
        S_RD: state_r <= S_RDWAIT;
        S_RDWAIT: begin
          c_r[ri_r[1:0]] <= rword;
          if (ri_r == 3'd3) begin
            if (c_r[0] == 16'd0 || c_r[1] == 16'd0 || c_r[2] == 16'd0 || rword == 16'd0) begin
              mm_r <= 10'd1;
              hm_r <= 8'd1;
              ri_r <= 3'd0;
              state_r <= S_HOLE;
            end else begin
              state_r <= S_PLANE1;
            end
          end else begin
            ri_r <= ri_r + 3'd1;
            state_r <= S_RD;
          end
        end
        S_PLANE1: state_r <= S_PLANE2;
        S_PLANE2: state_r <= S_PLANE3;
        S_PLANE3: state_r <= S_ROUND;
        S_ROUND: begin
          // exact /80 of 24-bit value via reciprocal and correction
          q_r <= 24'((48'(rsh) * 48'd838861) >> 26);
          state_r <= S_HWAIT;
          ri_r <= 3'd7;
        end
        S_HOLE: state_r <= S_HWAIT;
        S_HWAIT: begin
          if (ri_r == 3'd7) begin
            logic [23:0] q;
            q = (32'(q_r) * 32'd80 > 32'(rsh)) ? q_r - 24'd1 : q_r;
            if (acc < 0) res_r <= 16'd0;
            else if (q > 24'hFFFF) res_r <= 16'hFFFF;
            else res_r <= q[15:0];
            st_r <= eltbl_pkg::ST_INTERP;
            state_r <= S_OUT;
          end else if (rword == 16'd0) begin
            if (hm_r == 8'(HOLE_SEARCH_LIMIT)) begin
              res_r <= 16'd0;
              st_r <= eltbl_pkg::ST_HOLE_NONE;
              state_r <= S_OUT;
            end else begin
              hm_r <= hm_r + 8'd1;
              mm_r <= mm_r + 10'd1;
              ri_r <= 3'd0;
              state_r <= S_HOLE;
            end
          end else begin
            if (ri_r == 3'd0) w0_r <= rword;
            if (ri_r == 3'd4) begin
              res_r <= w0_r;
              st_r <= eltbl_pkg::ST_HOLE_SUB;
              state_r <= S_OUT;
            end else begin
              ri_r <= ri_r + 3'd1;
              state_r <= S_HOLE;
            end
          end
        end
        S_OUT: begin
          if (!ovld_r || out_tready) begin
            out_tdata <= res_r;
            out_tuser <= st_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE) && !mbusy;
  assign out_tvalid = ovld_r;

endmodule
